// File: design/plle_pkg.sv
// ----------------------------------------------------------------------------
// plle_pkg
// Shared types and constants of the positional linked-list engine.
// ----------------------------------------------------------------------------
package plle_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;

  // fixed field widths of the stream words
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 6;
  localparam int TDATA_W = 40;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 2;
  localparam int EXT_W  = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_WALK_INIT,
    ACT_WALK_STEP,
    ACT_READ_LINK,
    ACT_APPEND,
    ACT_INS_HEAD,
    ACT_INS_LINK1,
    ACT_INS_LINK2,
    ACT_DEL_HEAD,
    ACT_DEL_FETCH,
    ACT_DEL_UNLINK,
    ACT_RD_FETCH,
    ACT_RD_NEXT,
    ACT_EMIT_STATUS
  } dp_act_e;

  typedef struct packed {
    dp_act_e act;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic ins_bad;
    logic del_bad;
    logic pos_one;
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/plle_ram.sv
// ----------------------------------------------------------------------------
// plle_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/plle_dp.sv
// ----------------------------------------------------------------------------
// plle_dp
// Datapath: node value and link memories, free map, head/tail/length
// registers, walk pointer and the output word register.
// ----------------------------------------------------------------------------
module plle_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plle_pkg::dp_cmd_t            cmd_i,
  output plle_pkg::dp_stat_t           stat_o,
  input  logic [1:0]                   in_op_i,
  input  logic [plle_pkg::DATA_W-1:0]  in_value_i,
  input  logic [plle_pkg::POS_W-1:0]   in_pos_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [plle_pkg::DATA_W-1:0]  out_value_o,
  output logic [1:0]                   out_status_o,
  output logic [plle_pkg::COUNT_W-1:0] out_count_o,
  output logic                         out_last_o
);
  import plle_pkg::*;

  op_e                    op_q, op_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [CAPACITY-1:0]    free_q, free_d;
  logic [SLOT_W-1:0]      head_q, head_d;
  logic [SLOT_W-1:0]      tail_q, tail_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [SLOT_W-1:0]      cur_q, cur_d;
  logic                   follow_q, follow_d;
  logic [LEN_W-1:0]       cnt_q, cnt_d;
  logic [SLOT_W-1:0]      victim_q, victim_d;

  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      out_value_q, out_value_d;
  status_e                out_status_q, out_status_d;
  logic [COUNT_W-1:0]     out_count_q, out_count_d;
  logic                   out_last_q, out_last_d;

  logic [SLOT_W-1:0]      free_slot;
  logic [SLOT_W-1:0]      cur;
  logic [SLOT_W-1:0]      link_rdata;
  logic [VALUE_WIDTH-1:0] value_rdata;
  logic [CMP_W-1:0]       pos_x, len_x;
  logic [EXT_W-1:0]       in_ext, rd_ext;
  logic                   out_free;

  logic                   lk_we, lk_re, vl_we, vl_re;
  logic [SLOT_W-1:0]      lk_waddr, lk_wdata, vl_waddr, rd_addr;

  // lowest free slot first
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign cur      = follow_q ? link_rdata : cur_q;
  assign pos_x    = CMP_W'(pos_q);
  assign len_x    = CMP_W'(len_q);
  assign in_ext   = EXT_W'($signed(in_value_i));
  assign rd_ext   = EXT_W'(value_rdata);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.op       = op_q;
  assign stat_o.full     = (len_q == LEN_W'(CAPACITY));
  assign stat_o.empty    = (len_q == '0);
  assign stat_o.ins_bad  = (pos_x == '0) || (pos_x > len_x + CMP_W'(1));
  assign stat_o.del_bad  = (pos_x == '0) || (pos_x > len_x);
  assign stat_o.pos_one  = (pos_x == CMP_W'(1));
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.cnt_one  = (cnt_q == LEN_W'(1));
  assign stat_o.out_free = out_free;

  always_comb begin
    op_d         = op_q;
    val_d        = val_q;
    pos_d        = pos_q;
    free_d       = free_q;
    head_d       = head_q;
    tail_d       = tail_q;
    len_d        = len_q;
    cur_d        = cur_q;
    follow_d     = follow_q;
    cnt_d        = cnt_q;
    victim_d     = victim_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    lk_we        = 1'b0;
    lk_waddr     = free_slot;
    lk_wdata     = free_slot;
    lk_re        = 1'b0;
    vl_we        = 1'b0;
    vl_waddr     = free_slot;
    vl_re        = 1'b0;
    rd_addr      = cur;

    case (cmd_i.act)
      ACT_LOAD: begin
        op_d  = op_e'(in_op_i);
        val_d = in_ext[VALUE_WIDTH-1:0];
        pos_d = in_pos_i;
      end
      ACT_WALK_INIT: begin
        cur_d    = head_q;
        follow_d = 1'b0;
        cnt_d    = (op_q == OP_READ) ? len_q : LEN_W'(pos_x - CMP_W'(2));
      end
      ACT_WALK_STEP: begin
        lk_re    = 1'b1;
        cur_d    = cur;
        follow_d = 1'b1;
        cnt_d    = cnt_q - LEN_W'(1);
      end
      ACT_READ_LINK: begin
        lk_re    = 1'b1;
        cur_d    = cur;
        follow_d = 1'b0;
      end
      ACT_APPEND: begin
        vl_we    = 1'b1;
        lk_we    = (len_q != '0);
        lk_waddr = tail_q;
        if (len_q == '0) begin
          head_d = free_slot;
        end
        tail_d = free_slot;
        free_d = free_q & ~(CAPACITY'(1) << free_slot);
        len_d  = len_q + LEN_W'(1);
      end
      ACT_INS_HEAD: begin
        vl_we    = 1'b1;
        lk_we    = 1'b1;
        lk_wdata = head_q;
        head_d   = free_slot;
        if (len_q == '0) begin
          tail_d = free_slot;
        end
        free_d = free_q & ~(CAPACITY'(1) << free_slot);
        len_d  = len_q + LEN_W'(1);
      end
      ACT_INS_LINK1: begin
        vl_we    = 1'b1;
        lk_we    = 1'b1;
        lk_wdata = link_rdata;
      end
      ACT_INS_LINK2: begin
        lk_we    = 1'b1;
        lk_waddr = cur_q;
        if (pos_x == len_x + CMP_W'(1)) begin
          tail_d = free_slot;
        end
        free_d = free_q & ~(CAPACITY'(1) << free_slot);
        len_d  = len_q + LEN_W'(1);
      end
      ACT_DEL_HEAD: begin
        head_d = link_rdata;
        free_d = free_q | (CAPACITY'(1) << head_q);
        len_d  = len_q - LEN_W'(1);
      end
      ACT_DEL_FETCH: begin
        // link of prev names the victim, fetch the victim's own link
        victim_d = link_rdata;
        lk_re    = 1'b1;
        rd_addr  = link_rdata;
      end
      ACT_DEL_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = cur_q;
        lk_wdata = link_rdata;
        if (pos_x == len_x) begin
          tail_d = cur_q;
        end
        free_d = free_q | (CAPACITY'(1) << victim_q);
        len_d  = len_q - LEN_W'(1);
      end
      ACT_RD_FETCH: begin
        lk_re    = 1'b1;
        vl_re    = 1'b1;
        cur_d    = cur;
        follow_d = 1'b1;
      end
      ACT_RD_NEXT: begin
        out_valid_d  = 1'b1;
        out_value_d  = rd_ext[DATA_W-1:0];
        out_status_d = ST_OK;
        out_count_d  = len_x[COUNT_W-1:0];
        out_last_d   = (cnt_q == LEN_W'(1));
        cnt_d        = cnt_q - LEN_W'(1);
        // prefetch the next node while this word goes out
        lk_re        = (cnt_q != LEN_W'(1));
        vl_re        = (cnt_q != LEN_W'(1));
      end
      ACT_EMIT_STATUS: begin
        out_valid_d  = 1'b1;
        out_value_d  = '0;
        out_status_d = cmd_i.status;
        out_count_d  = len_x[COUNT_W-1:0];
        out_last_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  plle_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lk_we),
    .waddr_i(lk_waddr),
    .wdata_i(lk_wdata),
    .re_i   (lk_re),
    .raddr_i(rd_addr),
    .rdata_o(link_rdata)
  );

  plle_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (vl_we),
    .waddr_i(vl_waddr),
    .wdata_i(val_q),
    .re_i   (vl_re),
    .raddr_i(rd_addr),
    .rdata_o(value_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '1;
      head_q      <= '0;
      tail_q      <= '0;
      len_q       <= '0;
      cur_q       <= '0;
      follow_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_q      <= free_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      follow_q    <= follow_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    victim_q     <= victim_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_last_o   = out_last_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_free_matches_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_q) == CAPACITY - int'(len_q))
    else $error("free map out of step with list length");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == ACT_INS_LINK2) |=> (len_q == $past(len_q) + LEN_W'(1)))
    else $error("insert did not grow the list");

endmodule

// File: design/plle_ctrl.sv
// ----------------------------------------------------------------------------
// plle_ctrl
// Controller: sequences checks, link walks, memory updates and result words
// for one operation at a time.
// ----------------------------------------------------------------------------
module plle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plle_pkg::dp_stat_t  stat_i,
  output plle_pkg::dp_cmd_t   cmd_o
);
  import plle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_HEAD_RD,
    S_INS_WR1,
    S_INS_WR2,
    S_DEL_HEAD,
    S_DEL_FETCH,
    S_DEL_UNLINK,
    S_RD_FETCH,
    S_RD_EMIT,
    S_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cmd_o.act    = ACT_NONE;
    cmd_o.status = status_q;
    in_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ACT_LOAD;
          state_d   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_d = ST_OK;
        state_d  = S_EMIT;
        case (stat_i.op)
          OP_APPEND: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
            end else begin
              cmd_o.act = ACT_APPEND;
            end
          end
          OP_INSERT: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
            end else if (stat_i.ins_bad) begin
              status_d = ST_RANGE;
            end else if (stat_i.pos_one) begin
              cmd_o.act = ACT_INS_HEAD;
            end else begin
              cmd_o.act = ACT_WALK_INIT;
              state_d   = S_WALK;
            end
          end
          OP_DELETE: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else if (stat_i.del_bad) begin
              status_d = ST_RANGE;
            end else begin
              cmd_o.act = ACT_WALK_INIT;
              state_d   = stat_i.pos_one ? S_HEAD_RD : S_WALK;
            end
          end
          OP_READ: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              cmd_o.act = ACT_WALK_INIT;
              state_d   = S_RD_FETCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        // stop on the node in front of the target position
        if (stat_i.cnt_zero) begin
          cmd_o.act = ACT_READ_LINK;
          state_d   = (stat_i.op == OP_INSERT) ? S_INS_WR1 : S_DEL_FETCH;
        end else begin
          cmd_o.act = ACT_WALK_STEP;
        end
      end
      S_HEAD_RD: begin
        cmd_o.act = ACT_READ_LINK;
        state_d   = S_DEL_HEAD;
      end
      S_INS_WR1: begin
        cmd_o.act = ACT_INS_LINK1;
        state_d   = S_INS_WR2;
      end
      S_INS_WR2: begin
        cmd_o.act = ACT_INS_LINK2;
        state_d   = S_EMIT;
      end
      S_DEL_HEAD: begin
        cmd_o.act = ACT_DEL_HEAD;
        state_d   = S_EMIT;
      end
      S_DEL_FETCH: begin
        cmd_o.act = ACT_DEL_FETCH;
        state_d   = S_DEL_UNLINK;
      end
      S_DEL_UNLINK: begin
        cmd_o.act = ACT_DEL_UNLINK;
        state_d   = S_EMIT;
      end
      S_RD_FETCH: begin
        cmd_o.act = ACT_RD_FETCH;
        state_d   = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.act = ACT_RD_NEXT;
          if (stat_i.cnt_one) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.act = ACT_EMIT_STATUS;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  a_word_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.act == ACT_RD_NEXT || cmd_o.act == ACT_EMIT_STATUS) |-> stat_i.out_free)
    else $error("result word loaded over a pending one");

  a_walk_only_ins_del : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (stat_i.op == OP_INSERT || stat_i.op == OP_DELETE))
    else $error("link walk for an operation that needs none");

  a_load_then_decide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.act == ACT_LOAD) |=> (state_q == S_DECIDE))
    else $error("accepted word not decided next");

endmodule

// File: design/positional_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_linked_list_engine_top
// Ordered list of signed values kept as linked nodes in a bounded store.
//
// Input stream: tuser carries the operation (append, insert at position,
// delete at position, read whole list); tdata carries the value and the
// 1-based position. Output stream: one status word per append, insert,
// delete or empty read, else one per element; tlast on the final word.
// Every word carries the element count after the operation.
// One operation is in flight at a time; a new word is taken once the
// previous operation has loaded its last result into the output register.
// Append, insert at head and error statuses need no walk; insert and
// delete at p>1 first walk the links to the node at p-1; delete at
// head first reads the head's link; read-out walks from the head.
// The walk follows one link per cycle through the link memory read port.
// Reset empties the list and marks every slot free; no clearing pass.
// A stalled receiver holds the output word; read-out pauses with it.
// ----------------------------------------------------------------------------
module positional_linked_list_engine_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // element_value [31:0], position [37:32], zero pad [39:38]
  input  logic [plle_pkg::TDATA_W-1:0] s_axis_tdata_i,
  // operation [1:0]
  input  logic [1:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // read_value [31:0], element_count [37:32], zero pad [39:38]
  output logic [plle_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import plle_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [DATA_W-1:0]  out_value;
  logic [COUNT_W-1:0] out_count;

  plle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  plle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser_i),
    .in_value_i  (s_axis_tdata_i[DATA_W-1:0]),
    .in_pos_i    (s_axis_tdata_i[DATA_W+POS_W-1:DATA_W]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (out_value),
    .out_status_o(m_axis_tuser_o),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(TDATA_W - DATA_W - COUNT_W)'(0), out_count, out_value};

endmodule
